// ===== sv/ssac_pkg.sv =====
`timescale 1ns / 1ps
package ssac_pkg;

  // Sample format and configuration word widths.
  localparam int SAMPLE_W = 24;
  localparam int COEF_W = 18;
  localparam int COEFS_W = 3 * COEF_W;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = COEFS_W;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Unity in Q1.16 and the clamp on the soft-clip argument (5.0 in Q.16).
  localparam int ONE16 = 65536;
  localparam int TANH_LIMIT = 327680;

  // Pade 7/6 tanh coefficients.
  localparam int PADE_P0 = 378;
  localparam int PADE_P1 = 17325;
  localparam int PADE_P2 = 135135;
  localparam int PADE_Q1 = 3150;
  localparam int PADE_Q2 = 62370;

  // Quotient bits produced by the restoring divider.
  localparam int DIV_STEPS = 25;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_COEFS   = 4'd0,
    REG_LP_COEFS   = 4'd1,
    REG_SMEAR      = 4'd2,
    REG_DRIVE      = 4'd3,
    REG_MIX        = 4'd4,
    REG_IN_GAIN    = 4'd5,
    REG_OUT_GAIN   = 4'd6,
    REG_BYPASS     = 4'd7
  } ssac_reg_t;

  typedef struct packed {
    logic [COEFS_W-1:0] hp_coefs;
    logic [COEFS_W-1:0] lp_coefs;
    logic [16:0]        smear;
    logic [15:0]        drive;
    logic [16:0]        mix;
    logic [15:0]        in_gain;
    logic [15:0]        out_gain;
    logic               bypass;
  } ssac_cfg_t;

  // Datapath operations issued by the sequencer.
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_DRY_MUL, OP_DRY,
    OP_BQ_B0, OP_BQ_Y, OP_BQ_A1, OP_BQ_S1, OP_BQ_A2, OP_BQ_S2,
    OP_SM_A, OP_SM_B, OP_SM, OP_ARG_MUL, OP_ARG,
    OP_X2_MUL, OP_X2, OP_P1_MUL, OP_P1, OP_P2_MUL, OP_P2,
    OP_NUM_MUL, OP_NUM, OP_Q1_MUL, OP_Q1, OP_Q2_MUL, OP_Q2,
    OP_DIV, OP_CLIP, OP_MIX_A, OP_MIX_B, OP_MIX, OP_OUT_MUL, OP_OUT
  } ssac_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DRY_MUL, S_DRY,
    S_HP_B0, S_HP_Y, S_HP_A1, S_HP_S1, S_HP_A2, S_HP_S2,
    S_SM_A, S_SM_B, S_SM, S_ARG_MUL, S_ARG,
    S_X2_MUL, S_X2, S_P1_MUL, S_P1, S_P2_MUL, S_P2,
    S_NUM_MUL, S_NUM, S_Q1_MUL, S_Q1, S_Q2_MUL, S_Q2, S_DIV, S_CLIP,
    S_LP_B0, S_LP_Y, S_LP_A1, S_LP_S1, S_LP_A2, S_LP_S2,
    S_MIX_A, S_MIX_B, S_MIX, S_OUT_MUL, S_OUT
  } ssac_state_t;

  typedef struct packed {
    ssac_op_t op;
    logic     lp;
  } ssac_cmd_t;

  typedef struct packed {
    logic skip;
  } ssac_stat_t;

endpackage

// ===== sv/ssac_ctrl.sv =====
`timescale 1ns / 1ps
module ssac_ctrl import ssac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  ssac_stat_t stat,
  output ssac_cmd_t  cmd
);

  ssac_state_t          state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  // The output register may be reloaded once its word is gone or leaving.
  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_DRY_MUL;
      S_DRY_MUL: state_nxt = S_DRY;
      S_DRY:     state_nxt = stat.skip ? S_OUT_MUL : S_HP_B0;
      S_HP_B0:   state_nxt = S_HP_Y;
      S_HP_Y:    state_nxt = S_HP_A1;
      S_HP_A1:   state_nxt = S_HP_S1;
      S_HP_S1:   state_nxt = S_HP_A2;
      S_HP_A2:   state_nxt = S_HP_S2;
      S_HP_S2:   state_nxt = S_SM_A;
      S_SM_A:    state_nxt = S_SM_B;
      S_SM_B:    state_nxt = S_SM;
      S_SM:      state_nxt = S_ARG_MUL;
      S_ARG_MUL: state_nxt = S_ARG;
      S_ARG:     state_nxt = S_X2_MUL;
      S_X2_MUL:  state_nxt = S_X2;
      S_X2:      state_nxt = S_P1_MUL;
      S_P1_MUL:  state_nxt = S_P1;
      S_P1:      state_nxt = S_P2_MUL;
      S_P2_MUL:  state_nxt = S_P2;
      S_P2:      state_nxt = S_NUM_MUL;
      S_NUM_MUL: state_nxt = S_NUM;
      S_NUM:     state_nxt = S_Q1_MUL;
      S_Q1_MUL:  state_nxt = S_Q1;
      S_Q1:      state_nxt = S_Q2_MUL;
      S_Q2_MUL:  state_nxt = S_Q2;
      S_Q2:      state_nxt = S_DIV;
      S_DIV:     if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_CLIP;
      S_CLIP:    state_nxt = S_LP_B0;
      S_LP_B0:   state_nxt = S_LP_Y;
      S_LP_Y:    state_nxt = S_LP_A1;
      S_LP_A1:   state_nxt = S_LP_S1;
      S_LP_S1:   state_nxt = S_LP_A2;
      S_LP_A2:   state_nxt = S_LP_S2;
      S_LP_S2:   state_nxt = S_MIX_A;
      S_MIX_A:   state_nxt = S_MIX_B;
      S_MIX_B:   state_nxt = S_MIX;
      S_MIX:     state_nxt = S_OUT_MUL;
      S_OUT_MUL: state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.op = OP_NONE;
    cmd.lp = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      S_DRY_MUL: cmd.op = OP_DRY_MUL;
      S_DRY:     cmd.op = OP_DRY;
      S_HP_B0:   cmd.op = OP_BQ_B0;
      S_HP_Y:    cmd.op = OP_BQ_Y;
      S_HP_A1:   cmd.op = OP_BQ_A1;
      S_HP_S1:   cmd.op = OP_BQ_S1;
      S_HP_A2:   cmd.op = OP_BQ_A2;
      S_HP_S2:   cmd.op = OP_BQ_S2;
      S_SM_A:    cmd.op = OP_SM_A;
      S_SM_B:    cmd.op = OP_SM_B;
      S_SM:      cmd.op = OP_SM;
      S_ARG_MUL: cmd.op = OP_ARG_MUL;
      S_ARG:     cmd.op = OP_ARG;
      S_X2_MUL:  cmd.op = OP_X2_MUL;
      S_X2:      cmd.op = OP_X2;
      S_P1_MUL:  cmd.op = OP_P1_MUL;
      S_P1:      cmd.op = OP_P1;
      S_P2_MUL:  cmd.op = OP_P2_MUL;
      S_P2:      cmd.op = OP_P2;
      S_NUM_MUL: cmd.op = OP_NUM_MUL;
      S_NUM:     cmd.op = OP_NUM;
      S_Q1_MUL:  cmd.op = OP_Q1_MUL;
      S_Q1:      cmd.op = OP_Q1;
      S_Q2_MUL:  cmd.op = OP_Q2_MUL;
      S_Q2:      cmd.op = OP_Q2;
      S_DIV:     cmd.op = OP_DIV;
      S_CLIP:    cmd.op = OP_CLIP;
      S_LP_B0: begin cmd.op = OP_BQ_B0; cmd.lp = 1'b1; end
      S_LP_Y:  begin cmd.op = OP_BQ_Y;  cmd.lp = 1'b1; end
      S_LP_A1: begin cmd.op = OP_BQ_A1; cmd.lp = 1'b1; end
      S_LP_S1: begin cmd.op = OP_BQ_S1; cmd.lp = 1'b1; end
      S_LP_A2: begin cmd.op = OP_BQ_A2; cmd.lp = 1'b1; end
      S_LP_S2: begin cmd.op = OP_BQ_S2; cmd.lp = 1'b1; end
      S_MIX_A:   cmd.op = OP_MIX_A;
      S_MIX_B:   cmd.op = OP_MIX_B;
      S_MIX:     cmd.op = OP_MIX;
      S_OUT_MUL: cmd.op = OP_OUT_MUL;
      S_OUT:     if (out_free) cmd.op = OP_OUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // Divider step count and output valid flag.
  always_comb begin
    cnt_nxt = (state_r == S_DIV) ? cnt_r + 1'b1 : '0;
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (state_r == S_OUT && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // An accepted word always starts the gain multiply.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DRY_MUL))
    else $error("accepted word did not start processing");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < DIV_CNT_W'(DIV_STEPS)))
    else $error("divider step count out of range");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("output valid raised outside the output step");

endmodule

// ===== sv/ssac_dp.sv =====
`timescale 1ns / 1ps
module ssac_dp import ssac_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ssac_cmd_t                  cmd,
  output ssac_stat_t                 stat,
  input  ssac_cfg_t                  cfg,
  input  logic                       in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_channel,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [66:0] v);
    if (v > 67'(S_MAX)) return S_MAX;
    if (v < 67'(S_MIN)) return S_MIN;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -67'sh80000000) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Word registers.
  logic                       ch_r, ch_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt, dry_r, dry_nxt, y_r, y_nxt;
  logic signed [SAMPLE_W-1:0] sh_r, sh_nxt, sm_r, sm_nxt, res_r, res_nxt;
  logic signed [64:0]         prod_r, p0_r, p0_nxt, acc_r, acc_nxt;
  logic [18:0]                a_r, a_nxt;
  logic                       neg_r, neg_nxt;
  logic [20:0]                x2_r, x2_nxt;
  logic [35:0]                t_r, t_nxt;
  logic [37:0]                num_r, num_nxt, q_r, q_nxt;
  logic [38:0]                rem_r, rem_nxt;
  logic [DIV_STEPS-1:0]       dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic                       out_ch_r, out_ch_nxt;
  logic signed [SAMPLE_W-1:0] out_s_r, out_s_nxt;

  // Per-channel filter and smear state.
  logic signed [31:0]         hp_d0_r [CHANNELS];
  logic signed [31:0]         hp_d1_r [CHANNELS];
  logic signed [31:0]         lp_d0_r [CHANNELS];
  logic signed [31:0]         lp_d1_r [CHANNELS];
  logic signed [SAMPLE_W-1:0] smem_r  [CHANNELS];

  logic [CH_IW-1:0]           idx;
  logic [COEFS_W-1:0]         coefs;
  logic signed [COEF_W-1:0]   b0, a1, a2;
  logic signed [31:0]         d0, d1;
  logic [16:0]                k, kc, m, mc;
  logic signed [39:0]         mul_a;
  logic signed [24:0]         mul_b;
  logic signed [64:0]         mul_p;
  logic                       mul_en;
  logic                       wr_d0, wr_d1, wr_sm;
  logic signed [31:0]         wr_val;
  logic signed [66:0]         v, w, arg;
  logic [38:0]                r2;
  logic                       ge;
  logic signed [25:0]         qs;

  assign idx = CH_IW'(ch_r);
  assign stat.skip = cfg.bypass || (32'(ch_r) >= CHANNELS);

  // Coefficient and weight selection.
  assign coefs = cmd.lp ? cfg.lp_coefs : cfg.hp_coefs;
  assign b0 = signed'(coefs[COEF_W-1:0]);
  assign a1 = signed'(coefs[2*COEF_W-1:COEF_W]);
  assign a2 = signed'(coefs[3*COEF_W-1:2*COEF_W]);
  assign d0 = cmd.lp ? lp_d0_r[idx] : hp_d0_r[idx];
  assign d1 = cmd.lp ? lp_d1_r[idx] : hp_d1_r[idx];
  assign k  = (cfg.smear > 17'(ONE16)) ? 17'(ONE16) : cfg.smear;
  assign m  = (cfg.mix > 17'(ONE16)) ? 17'(ONE16) : cfg.mix;
  assign kc = 17'(ONE16) - k;
  assign mc = 17'(ONE16) - m;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_DRY_MUL: begin mul_a = 40'(x_r); mul_b = signed'(25'(cfg.in_gain)); end
      OP_BQ_B0: begin
        mul_a = cmd.lp ? 40'(sh_r) : 40'(dry_r);
        mul_b = 25'(b0);
      end
      OP_BQ_A1:   begin mul_a = 40'(y_r); mul_b = 25'(a1); end
      OP_BQ_A2:   begin mul_a = 40'(y_r); mul_b = 25'(a2); end
      OP_SM_A:    begin mul_a = 40'(y_r); mul_b = signed'(25'(kc)); end
      OP_SM_B:    begin mul_a = 40'(smem_r[idx]); mul_b = signed'(25'(k)); end
      OP_ARG_MUL: begin mul_a = 40'(sm_r); mul_b = signed'(25'(cfg.drive)); end
      OP_X2_MUL:  begin mul_a = signed'(40'(a_r)); mul_b = signed'(25'(a_r)); end
      OP_P1_MUL: begin
        mul_a = signed'(40'(x2_r) + (40'(PADE_P0) << 16));
        mul_b = signed'(25'(x2_r));
      end
      OP_P2_MUL:  begin mul_a = signed'(40'(t_r)); mul_b = signed'(25'(x2_r)); end
      OP_NUM_MUL: begin mul_a = signed'(40'(t_r)); mul_b = signed'(25'(a_r)); end
      OP_Q1_MUL: begin
        // 28 * x2 built from two shifts
        mul_a = signed'((40'(x2_r) << 5) - (40'(x2_r) << 2) + (40'(PADE_Q1) << 16));
        mul_b = signed'(25'(x2_r));
      end
      OP_Q2_MUL:  begin mul_a = signed'(40'(t_r)); mul_b = signed'(25'(x2_r)); end
      OP_MIX_A:   begin mul_a = 40'(y_r); mul_b = signed'(25'(m)); end
      OP_MIX_B:   begin mul_a = 40'(dry_r); mul_b = signed'(25'(mc)); end
      OP_OUT_MUL: begin mul_a = 40'(res_r); mul_b = signed'(25'(cfg.out_gain)); end
      default:    mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Operation results.
  always_comb begin
    ch_nxt = ch_r;     x_nxt = x_r;       dry_nxt = dry_r;   y_nxt = y_r;
    sh_nxt = sh_r;     sm_nxt = sm_r;     res_nxt = res_r;   p0_nxt = p0_r;
    acc_nxt = acc_r;   a_nxt = a_r;       neg_nxt = neg_r;   x2_nxt = x2_r;
    t_nxt = t_r;       num_nxt = num_r;   q_nxt = q_r;       rem_nxt = rem_r;
    dvd_nxt = dvd_r;   quo_nxt = quo_r;   out_ch_nxt = out_ch_r;
    out_s_nxt = out_s_r;
    wr_d0 = 1'b0;  wr_d1 = 1'b0;  wr_sm = 1'b0;  wr_val = '0;
    v = '0;  w = '0;  arg = '0;  r2 = '0;  ge = 1'b0;  qs = '0;
    case (cmd.op)
      OP_LOAD: begin ch_nxt = in_channel; x_nxt = in_sample; end
      OP_DRY: begin
        v = (67'(prod_r) + 67'sd2048) >>> 12;
        dry_nxt = sat_s(v);
        res_nxt = sat_s(v);
      end
      OP_BQ_Y: begin
        v = (67'(prod_r) + (67'(d0) <<< 16) + 67'sd32768) >>> 16;
        y_nxt = sat_s(v);
        p0_nxt = prod_r;
      end
      OP_BQ_S1: begin
        // Numerator middle tap is -2*b0 for highpass and +2*b0 for lowpass.
        w = cmd.lp ? (67'(p0_r) <<< 1) : -(67'(p0_r) <<< 1);
        v = ((w - 67'(prod_r) + 67'sd32768) >>> 16) + 67'(d1);
        wr_d0 = 1'b1;
        wr_val = sat32(v);
      end
      OP_BQ_S2: begin
        v = (67'(p0_r) - 67'(prod_r) + 67'sd32768) >>> 16;
        wr_d1 = 1'b1;
        wr_val = sat32(v);
      end
      OP_SM_B: acc_nxt = prod_r;
      OP_SM: begin
        v = (67'(acc_r) + 67'(prod_r) + 67'sd32768) >>> 16;
        sm_nxt = sat_s(v);
        wr_sm = 1'b1;
      end
      OP_ARG: begin
        arg = (67'(prod_r) + 67'sd131072) >>> 18;
        if (arg > 67'(TANH_LIMIT)) begin
          a_nxt = 19'(TANH_LIMIT);
          neg_nxt = 1'b0;
        end else if (arg < -67'(TANH_LIMIT)) begin
          a_nxt = 19'(TANH_LIMIT);
          neg_nxt = 1'b1;
        end else begin
          neg_nxt = arg[66];
          a_nxt = arg[66] ? 19'(-arg) : 19'(arg);
        end
      end
      OP_X2: begin
        v = 67'(prod_r) + 67'sd32768;
        x2_nxt = v[36:16];
      end
      OP_P1: begin
        v = ((67'(prod_r) + 67'sd32768) >>> 16) + (67'(PADE_P1) <<< 16);
        t_nxt = 36'(v);
      end
      OP_P2, OP_Q1: begin
        v = (67'(prod_r) + 67'sd32768) >>> 16;
        w = (cmd.op == OP_P2) ? (67'(PADE_P2) <<< 16) : (67'(PADE_Q2) <<< 16);
        t_nxt = 36'(v + w);
      end
      OP_NUM: begin
        v = (67'(prod_r) + 67'sd32768) >>> 16;
        num_nxt = 38'(v);
      end
      OP_Q2: begin
        v = ((67'(prod_r) + 67'sd32768) >>> 16) + (67'(PADE_P2) <<< 16);
        q_nxt = 38'(v);
        rem_nxt = 39'(num_r >> 2);
        dvd_nxt = {num_r[1:0], {(DIV_STEPS-2){1'b0}}};
        quo_nxt = '0;
      end
      OP_DIV: begin
        // One restoring step: shift in a dividend bit, subtract when it fits.
        r2 = {rem_r[37:0], dvd_r[DIV_STEPS-1]};
        ge = r2 >= {1'b0, q_r};
        rem_nxt = ge ? r2 - {1'b0, q_r} : r2;
        quo_nxt = {quo_r[DIV_STEPS-2:0], ge};
        dvd_nxt = dvd_r << 1;
      end
      OP_CLIP: begin
        qs = signed'(26'(quo_r));
        sh_nxt = neg_r ? sat_s(-67'(qs)) : sat_s(67'(qs));
      end
      OP_MIX_B: acc_nxt = prod_r;
      OP_MIX: begin
        v = (67'(acc_r) + 67'(prod_r) + 67'sd32768) >>> 16;
        res_nxt = sat_s(v);
      end
      OP_OUT: begin
        v = (67'(prod_r) + 67'sd2048) >>> 12;
        out_s_nxt = sat_s(v);
        out_ch_nxt = ch_r;
      end
      default: ;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;     x_r <= x_nxt;       dry_r <= dry_nxt;   y_r <= y_nxt;
    sh_r <= sh_nxt;     sm_r <= sm_nxt;     res_r <= res_nxt;   p0_r <= p0_nxt;
    acc_r <= acc_nxt;   a_r <= a_nxt;       neg_r <= neg_nxt;   x2_r <= x2_nxt;
    t_r <= t_nxt;       num_r <= num_nxt;   q_r <= q_nxt;       rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;   quo_r <= quo_nxt;   out_ch_r <= out_ch_nxt;
    out_s_r <= out_s_nxt;
    if (mul_en) prod_r <= mul_p;
  end

  // Channel state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hp_d0_r[i] <= '0;
        hp_d1_r[i] <= '0;
        lp_d0_r[i] <= '0;
        lp_d1_r[i] <= '0;
        smem_r[i] <= '0;
      end
    end else begin
      if (wr_d0 && !cmd.lp) hp_d0_r[idx] <= wr_val;
      if (wr_d0 && cmd.lp)  lp_d0_r[idx] <= wr_val;
      if (wr_d1 && !cmd.lp) hp_d1_r[idx] <= wr_val;
      if (wr_d1 && cmd.lp)  lp_d1_r[idx] <= wr_val;
      if (wr_sm) smem_r[idx] <= sm_nxt;
    end
  end

  assign out_channel = out_ch_r;
  assign out_sample = out_s_r;

  a_arg_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_X2_MUL) |-> (a_r <= 19'(TANH_LIMIT)))
    else $error("soft-clip argument above the clamp");

  a_rem_below_q: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV) |-> (rem_r < {1'b0, q_r}))
    else $error("divider remainder not below divisor");

endmodule

// ===== sv/smear_saturation_audio_chain_core.sv =====
`timescale 1ns / 1ps
// A word runs input gain, highpass, smear, tanh soft clip, lowpass, mix and
// output gain; bypass, or a channel beyond CHANNELS, skips from input gain to
// output gain. No new word is taken before the last result is registered; the
// pace is set by the single shared multiplier and the 25-step restoring divider.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid flag and
// all filter and smear state, and loads the register defaults.
module smear_saturation_audio_chain_core import ssac_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [23:0] sample_in
  input  logic                  in_tuser,   // [0] channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [23:0] sample_out
  output logic                  out_tuser,  // [0] channel_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ssac_cfg_t                  cfg_r, cfg_nxt;
  ssac_cmd_t                  cmd;
  ssac_stat_t                 stat;
  logic signed [SAMPLE_W-1:0] out_sample;

  assign cfg_ready = 1'b1;

  // Register file decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HP_COEFS: cfg_nxt.hp_coefs = cfg_data;
        REG_LP_COEFS: cfg_nxt.lp_coefs = cfg_data;
        REG_SMEAR:    cfg_nxt.smear = cfg_data[16:0];
        REG_DRIVE:    cfg_nxt.drive = cfg_data[15:0];
        REG_MIX:      cfg_nxt.mix = cfg_data[16:0];
        REG_IN_GAIN:  cfg_nxt.in_gain = cfg_data[15:0];
        REG_OUT_GAIN: cfg_nxt.out_gain = cfg_data[15:0];
        REG_BYPASS:   cfg_nxt.bypass = cfg_data[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hp_coefs <= '0;
      cfg_r.lp_coefs <= '0;
      cfg_r.smear    <= 17'd22938;
      cfg_r.drive    <= 16'd22938;
      cfg_r.mix      <= 17'd32768;
      cfg_r.in_gain  <= 16'd4096;
      cfg_r.out_gain <= 16'd4096;
      cfg_r.bypass   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ssac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ssac_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg_r),
    .in_channel  (in_tuser),
    .in_sample   (signed'(in_tdata)),
    .out_channel (out_tuser),
    .out_sample  (out_sample)
  );

  assign out_tdata = unsigned'(out_sample);

endmodule
